// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define BMPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent forces a consequent in the same cycle.
`define BMPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/bmpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmpq_pkg;

  // Input item: palette load or pixel.
  typedef struct packed {
    logic       kind;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  // Result item: one byte of the pixel-data stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_end;
    logic       last;
  } out_item_t;

  // Item kinds.
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEPTH_MODE    = 2'd0;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [1:0] REG_ROW_PIXELS    = 2'd2;

  // Pixel depth codes.
  localparam logic [1:0] MODE_1BIT  = 2'd0;
  localparam logic [1:0] MODE_4BIT  = 2'd1;
  localparam logic [1:0] MODE_8BIT  = 2'd2;
  localparam logic [1:0] MODE_24BIT = 2'd3;

  localparam int CFG_W        = 16;
  localparam int DIST_W       = 18;
  localparam logic [8:0] NIBBLE_ENTRIES = 9'd16;
  localparam logic [7:0] NIB_HI = 8'hF0;
  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

`default_nettype wire

// File: hdl/bmp_pixel_palette_quantize_pack.sv
// BMP pixel-data encoder with nearest-color palette quantization.
// Input channel (in_valid / in_stall / in_item): each item either loads one
// palette entry (kind 0) or encodes one RGB pixel (kind 1), pixels in row
// order. Result channel (out_valid / out_stall / out_item): BMP pixel-data
// bytes, row_end on the last padded byte of a row, last on the final byte
// an item produces. Configuration is written through cfg_we / cfg_index /
// cfg_data while the block is idle.
// Operation: a palette load produces nothing. A pixel walks the palette in
// a synchronous RAM, one entry per cycle, through a read / square / compare
// pipeline that holds the block until the search ends; the entries searched
// are up to PALETTE_DEPTH in eight bit mode, 16 in four bit, 2 in one bit
// and none in 24 bit mode. The pixel's bytes (0 to 6) then leave at one per
// cycle while out_stall is low, and the input reopens after the last one
// loads.
// The output register lets the next item be accepted while the final byte
// of the previous one still waits; a stalled receiver holds that byte and
// freezes the emit sequence.
// Reset (synchronous, rst_n low): 24 bit mode, empty palette, one pixel per
// row, fresh stream. Palette contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bmp_pixel_palette_quantize_pack #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bmpq_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bmpq_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  import bmpq_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [8:0]      pcount_r, pcount_nxt;
  logic [15:0]     rowpix_r, rowpix_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic [CW-1:0]   limit_r, limit_nxt;
  logic            s1_vld_r, s1_vld_nxt;
  logic            s2_vld_r, s2_vld_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [AW-1:0]   best_idx_r, best_idx_nxt;
  logic [2:0]      left_r, left_nxt;
  logic [7:0]      pack_r, pack_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [15:0]     col_r, col_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic            rdone_r, rdone_nxt;
  logic            out_vld_r, out_vld_nxt;

  // Payload
  logic [7:0]      px_red_r, px_green_r, px_blue_r;
  logic [AW-1:0]   s1_idx_r, s2_idx_r;
  logic [15:0]     sq_red_r, sq_green_r, sq_blue_r;
  logic [23:0]     q_r, q_nxt;
  out_item_t       out_r;

  // Handshake and RAM signals
  logic            in_acc;
  logic            pal_we;
  logic            rd_en;
  logic [23:0]     rd_data;
  logic            search_done;
  logic            fin_go;
  logic            load;

  // Distance and pack datapath
  logic [7:0]      dr, dg, db;
  logic [DIST_W-1:0] dist_sum;
  logic [8:0]      cnt9, lim9;
  logic            row_done;
  logic [7:0]      idx8;
  logic [7:0]      pk_a;
  logic [2:0]      fill_a;
  logic            flush;
  logic [1:0]      main_n;
  logic [1:0]      pad_n;
  logic [2:0]      total_n;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pal_we   = in_acc && (in_item.kind == KIND_PALETTE)
                    && ({1'b0, in_item.entry_index} < DEPTH9);

  // Issue one palette read per cycle until the search limit is reached.
  assign rd_en = (state_r == ST_SEARCH) && (iss_r != limit_r);

  bmpq_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_item.entry_index[AW-1:0]),
    .wdata ({in_item.red, in_item.green, in_item.blue}),
    .re    (rd_en),
    .raddr (iss_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Absolute component differences against the returned entry.
  always_comb begin
    dr = (px_red_r   > rd_data[23:16]) ? px_red_r   - rd_data[23:16]
                                       : rd_data[23:16] - px_red_r;
    dg = (px_green_r > rd_data[15:8])  ? px_green_r - rd_data[15:8]
                                       : rd_data[15:8] - px_green_r;
    db = (px_blue_r  > rd_data[7:0])   ? px_blue_r  - rd_data[7:0]
                                       : rd_data[7:0] - px_blue_r;
  end

  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

  assign search_done = (state_r == ST_SEARCH) && (iss_r == limit_r)
                       && !s1_vld_r && !s2_vld_r;
  assign fin_go = search_done;
  assign load   = (state_r == ST_EMIT) && (!out_vld_r || !out_stall);

  // Search limit for the pixel about to be accepted.
  always_comb begin
    cnt9 = (pcount_r > DEPTH9) ? DEPTH9 : pcount_r;
    case (mode_r)
      MODE_8BIT: lim9 = cnt9;
      MODE_4BIT: lim9 = (cnt9 < NIBBLE_ENTRIES) ? cnt9 : NIBBLE_ENTRIES;
      MODE_1BIT: lim9 = (cnt9 >= 9'd2) ? 9'd2 : 9'd0;
      default:   lim9 = 9'd0;
    endcase
  end

  // Pack the winning index (four and one bit modes) and size the byte burst for this pixel.
  always_comb begin
    row_done = (col_r == (rowpix_r - 16'd1));
    idx8     = 8'(best_idx_r);
    pk_a     = pack_r;
    fill_a   = fill_r;
    flush    = 1'b0;
    main_n   = 2'd0;
    case (mode_r)
      MODE_24BIT: begin
        main_n = 2'd3;
      end
      MODE_8BIT: begin
        main_n = 2'd1;
      end
      MODE_4BIT: begin
        pk_a   = (fill_r == 3'd0) ? ((idx8 << 4) & NIB_HI)
                                  : ((pack_r & NIB_HI) | (idx8 & NIB_LO));
        fill_a = fill_r + 3'd1;
        flush  = (fill_a >= 3'd2) || row_done;
        main_n = flush ? 2'd1 : 2'd0;
      end
      default: begin
        pk_a   = pack_r | ({7'd0, idx8[0]} << (LAST_BIT - fill_r));
        fill_a = fill_r + 3'd1;
        flush  = (fill_a == 3'd0) || row_done;
        main_n = flush ? 2'd1 : 2'd0;
      end
    endcase
    // Pad the row out to a four-byte boundary.
    pad_n   = row_done ? 2'(2'd0 - (phase_r + main_n)) : 2'd0;
    total_n = 3'(main_n) + 3'(pad_n);
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pcount_nxt   = pcount_r;
    rowpix_nxt   = rowpix_r;
    iss_nxt      = iss_r;
    limit_nxt    = limit_r;
    s1_vld_nxt   = rd_en;
    s2_vld_nxt   = s1_vld_r;
    best_d_nxt   = best_d_r;
    best_idx_nxt = best_idx_r;
    left_nxt     = left_r;
    pack_nxt     = pack_r;
    fill_nxt     = fill_r;
    col_nxt      = col_r;
    phase_nxt    = phase_r;
    rdone_nxt    = rdone_r;
    out_vld_nxt  = out_vld_r && out_stall;
    q_nxt        = q_r;

    if (rd_en) begin
      iss_nxt = iss_r + CW'(1);
    end

    // Keep the first (lowest) index on equal distance.
    if (s2_vld_r && (dist_sum < best_d_r)) begin
      best_d_nxt   = dist_sum;
      best_idx_nxt = s2_idx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_item.kind == KIND_PIXEL)) begin
          state_nxt    = ST_SEARCH;
          iss_nxt      = '0;
          limit_nxt    = lim9[CW-1:0];
          best_d_nxt   = '1;
          best_idx_nxt = '0;
        end
      end
      ST_SEARCH: begin
        if (fin_go) begin
          if (mode_r == MODE_24BIT) begin
            q_nxt = {px_red_r, px_green_r, px_blue_r};
          end else if (mode_r == MODE_8BIT) begin
            q_nxt = {16'd0, idx8};
          end else begin
            q_nxt = {16'd0, pk_a};
            if (flush) begin
              pack_nxt = '0;
              fill_nxt = '0;
            end else begin
              pack_nxt = pk_a;
              fill_nxt = fill_a;
            end
          end
          if (row_done) begin
            col_nxt  = '0;
            pack_nxt = '0;
            fill_nxt = '0;
          end else begin
            col_nxt = col_r + 16'd1;
          end
          phase_nxt = phase_r + total_n[1:0];
          rdone_nxt = row_done;
          left_nxt  = total_n;
          state_nxt = (total_n == 3'd0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_vld_nxt = 1'b1;
          q_nxt       = {8'd0, q_r[23:8]};
          left_nxt    = left_r - 3'd1;
          if (left_r == 3'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes must arrive only while idle; the block does not enforce
    // this. A depth or row change restarts the stream.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_MODE: begin
          mode_nxt  = cfg_data[1:0];
          pack_nxt  = '0;
          fill_nxt  = '0;
          col_nxt   = '0;
          phase_nxt = '0;
        end
        REG_PALETTE_COUNT: begin
          pcount_nxt = cfg_data[8:0];
        end
        REG_ROW_PIXELS: begin
          rowpix_nxt = cfg_data;
          pack_nxt   = '0;
          fill_nxt   = '0;
          col_nxt    = '0;
          phase_nxt  = '0;
        end
        default: begin
          // Index beyond the register list: drop the write.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_24BIT;
      pcount_r   <= '0;
      rowpix_r   <= 16'd1;
      iss_r      <= '0;
      limit_r    <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      best_d_r   <= '1;
      best_idx_r <= '0;
      left_r     <= '0;
      pack_r     <= '0;
      fill_r     <= '0;
      col_r      <= '0;
      phase_r    <= '0;
      rdone_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      pcount_r   <= pcount_nxt;
      rowpix_r   <= rowpix_nxt;
      iss_r      <= iss_nxt;
      limit_r    <= limit_nxt;
      s1_vld_r   <= s1_vld_nxt;
      s2_vld_r   <= s2_vld_nxt;
      best_d_r   <= best_d_nxt;
      best_idx_r <= best_idx_nxt;
      left_r     <= left_nxt;
      pack_r     <= pack_nxt;
      fill_r     <= fill_nxt;
      col_r      <= col_nxt;
      phase_r    <= phase_nxt;
      rdone_r    <= rdone_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Pixel, pipeline and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_red_r   <= in_item.red;
      px_green_r <= in_item.green;
      px_blue_r  <= in_item.blue;
    end
    s1_idx_r   <= iss_r[AW-1:0];
    s2_idx_r   <= s1_idx_r;
    sq_red_r   <= 16'(dr) * 16'(dr);
    sq_green_r <= 16'(dg) * 16'(dg);
    sq_blue_r  <= 16'(db) * 16'(db);
    q_r        <= q_nxt;
    if (load) begin
      out_r.data_byte <= q_r[7:0];
      out_r.last      <= (left_r == 3'd1);
      out_r.row_end   <= (left_r == 3'd1) && rdone_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  `BMPQ_ASSERT(a_issue_bound, clk, rst_n, (iss_r <= limit_r), "read issue ran past the limit")
  `BMPQ_ASSERT_IMPL(a_pipe_in_search, clk, rst_n, (s1_vld_r || s2_vld_r), (state_r == ST_SEARCH), "palette read in flight outside search")
  `BMPQ_ASSERT_IMPL(a_emit_nonempty, clk, rst_n, (state_r == ST_EMIT), (left_r != 3'd0), "emit with no bytes left")
  `BMPQ_ASSERT_IMPL(a_row_aligned, clk, rst_n, ((state_r == ST_EMIT) && rdone_r), (phase_r == 2'd0), "row end not on a four-byte boundary")
  `BMPQ_ASSERT_IMPL(a_nibble_fill, clk, rst_n, (mode_r == MODE_4BIT), (fill_r < 3'd2), "four bit pack holds more than one nibble")

endmodule

`default_nettype wire

// File: hdl/bmpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
